// File: sv/radix_integer_to_ascii_top_assert.svh
// ----------------------------------------------------------------------------
// radix integer to ascii assertion macros
// shared property forms for the stream port checks
// ----------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TO_ASCII_TOP_ASSERT_SVH
`define RADIX_INTEGER_TO_ASCII_TOP_ASSERT_SVH

// same-cycle implication under the block clock and reset
`define RITOA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under the block clock and reset
`define RITOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ritoa_pkg.sv
// ----------------------------------------------------------------------------
// ritoa_pkg
// types, constants and helpers of the radix integer to ascii converter
// ----------------------------------------------------------------------------
package ritoa_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned MAX_CHARS_DEF  = 48;

  localparam int unsigned NUMBER_W = 32;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned WIDTH_W  = 6;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGIT_W  = 6;
  localparam int unsigned IN_W     = 56;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_LOWER = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] ASCII_X     = 8'h78;
  localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_PLAN,
    ST_PAD_LEAD,
    ST_SIGN,
    ST_PFX_ZERO,
    ST_PFX_X,
    ST_PAD_FILL,
    ST_DIGIT,
    ST_ERR
  } state_e;

  // digit value 0..35 to its ascii character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? ASCII_UPPER : ASCII_LOWER;
    if (d <= 6'd9) begin
      digit_char = ASCII_ZERO + CHAR_W'(d);
    end else begin
      digit_char = base + CHAR_W'(d - 6'd10);
    end
  endfunction

endpackage

// File: sv/radix_integer_to_ascii_top.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_top
// converts one integer per request into ascii text in radix 2 to 36
// ----------------------------------------------------------------------------
// One request carries a number and its formatting; the block answers with the
// text one character per output beat, most significant first, tlast on the
// final one. Digits come from a shared restoring divider that retires one
// quotient bit per cycle. The block takes one request at a time;
// s_axis_tready is high only while it is idle. A radix outside 2 to 36
// gives a single beat with char 0, tlast and tuser set.
module radix_integer_to_ascii_top
  import ritoa_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,  // 8..45
  parameter int unsigned MAX_CHARS  = MAX_CHARS_DEF    // 16..64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // number[31:0] radix[37:32] upper_case[38] treat_signed[39]
  // pad_width[45:40] pad_char[53:46] hex_prefix[54] zero[55]
  input  logic [IN_W-1:0]   s_axis_tdata,
  // character stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [CHAR_W-1:0] m_axis_tdata,   // char_code[7:0]
  output logic              m_axis_tlast,   // last
  output logic              m_axis_tuser    // bad_radix[0]
);

  localparam int unsigned BIT_W = $clog2(VALUE_BITS);
  localparam int unsigned ND_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned CNT_W = $clog2(64 + MAX_CHARS + VALUE_BITS);

  // request fields
  logic [NUMBER_W-1:0] in_number;
  logic [RADIX_W-1:0]  in_radix;
  logic                in_upper, in_signed, in_pfx;
  logic [WIDTH_W-1:0]  in_width;
  logic [CHAR_W-1:0]   in_pad;
  logic [VALUE_BITS-1:0] in_value;
  logic                in_neg, in_bad;

  assign in_number = s_axis_tdata[31:0];
  assign in_radix  = s_axis_tdata[37:32];
  assign in_upper  = s_axis_tdata[38];
  assign in_signed = s_axis_tdata[39];
  assign in_width  = s_axis_tdata[45:40];
  assign in_pad    = s_axis_tdata[53:46];
  assign in_pfx    = s_axis_tdata[54];
  assign in_value  = VALUE_BITS'(in_number);
  assign in_neg    = in_signed && in_value[VALUE_BITS-1];
  assign in_bad    = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);

  state_e state_q, state_d;

  // captured formatting
  logic [RADIX_W-1:0]  radix_q, radix_d;
  logic                upper_q, upper_d;
  logic                pfx_q, pfx_d;
  logic                neg_q, neg_d;
  logic [WIDTH_W-1:0]  width_q, width_d;
  logic [CHAR_W-1:0]   pad_q, pad_d;

  // divider: value/quotient shift register, partial remainder, bit counter
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [BIT_W-1:0]      bit_q, bit_d;

  // digit stack, least significant pushed first, top read at entry 0
  logic [DIGIT_W-1:0] dig_q [VALUE_BITS];
  logic [DIGIT_W-1:0] dig_d [VALUE_BITS];
  logic [ND_W-1:0]    nd_q, nd_d;

  logic [CNT_W-1:0] pad_cnt_q, pad_cnt_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              out_last_q, out_last_d;
  logic              out_bad_q, out_bad_d;

  // divider step
  logic [DIGIT_W:0]      trial;
  logic                  q_bit;
  logic [DIGIT_W-1:0]    rem_next;
  logic [VALUE_BITS-1:0] quot_next;
  logic                  digit_done;

  assign trial      = {rem_q, val_q[VALUE_BITS-1]};
  assign q_bit      = trial >= {1'b0, radix_q};
  assign rem_next   = q_bit ? DIGIT_W'(trial - {1'b0, radix_q}) : trial[DIGIT_W-1:0];
  assign quot_next  = {val_q[VALUE_BITS-2:0], q_bit};
  assign digit_done = (bit_q == '0);

  // padding count: width minus text length, never below zero
  logic [CNT_W-1:0] width_sat, text_len, pads;
  logic             space;

  assign space     = (pad_q == ASCII_SPACE);
  assign width_sat = (CNT_W'(width_q) > CNT_W'(MAX_CHARS)) ? CNT_W'(MAX_CHARS)
                                                            : CNT_W'(width_q);
  assign text_len  = CNT_W'(nd_q) + (pfx_q ? CNT_W'(2) : '0) + (neg_q ? CNT_W'(1) : '0);
  assign pads      = (width_sat > text_len) ? (width_sat - text_len) : '0;

  // a beat may be loaded when the output register is free or being drained
  logic load;
  assign load = !out_valid_q || m_axis_tready;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // segment order: lead pad, sign, prefix, fill pad, digits
  state_e after_pfx, after_sign, after_lead;
  assign after_pfx  = (!space && pads != '0) ? ST_PAD_FILL : ST_DIGIT;
  assign after_sign = pfx_q ? ST_PFX_ZERO : after_pfx;
  assign after_lead = neg_q ? ST_SIGN : after_sign;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = in_bad ? ST_ERR : ST_DIV;
        end
      end
      ST_DIV: begin
        if (digit_done && quot_next == '0) begin
          state_d = ST_PLAN;
        end
      end
      ST_PLAN: begin
        state_d = (space && pads != '0) ? ST_PAD_LEAD : after_lead;
      end
      ST_PAD_LEAD: begin
        if (load && pad_cnt_q == CNT_W'(1)) begin
          state_d = after_lead;
        end
      end
      ST_SIGN: begin
        if (load) begin
          state_d = after_sign;
        end
      end
      ST_PFX_ZERO: begin
        if (load) begin
          state_d = ST_PFX_X;
        end
      end
      ST_PFX_X: begin
        if (load) begin
          state_d = after_pfx;
        end
      end
      ST_PAD_FILL: begin
        if (load && pad_cnt_q == CNT_W'(1)) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (load && nd_q == ND_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // beat to emit in each state
  logic              emit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic              emit_bad;

  always_comb begin
    emit      = 1'b0;
    emit_char = ASCII_NUL;
    emit_last = 1'b0;
    emit_bad  = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE:     s_axis_tready = 1'b1;
      ST_DIV:      ;
      ST_PLAN:     ;
      ST_PAD_LEAD: begin
        emit      = 1'b1;
        emit_char = pad_q;
      end
      ST_SIGN: begin
        emit      = 1'b1;
        emit_char = ASCII_MINUS;
      end
      ST_PFX_ZERO: begin
        emit      = 1'b1;
        emit_char = ASCII_ZERO;
      end
      ST_PFX_X: begin
        emit      = 1'b1;
        emit_char = ASCII_X;
      end
      ST_PAD_FILL: begin
        emit      = 1'b1;
        emit_char = pad_q;
      end
      ST_DIGIT: begin
        emit      = 1'b1;
        emit_char = digit_char(dig_q[0], upper_q);
        emit_last = (nd_q == ND_W'(1));
      end
      ST_ERR: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        emit_bad  = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    radix_d   = radix_q;
    upper_d   = upper_q;
    pfx_d     = pfx_q;
    neg_d     = neg_q;
    width_d   = width_q;
    pad_d     = pad_q;
    val_d     = val_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    nd_d      = nd_q;
    pad_cnt_d = pad_cnt_q;
    dig_d     = dig_q;

    if (accept) begin
      radix_d = in_radix;
      upper_d = in_upper;
      pfx_d   = in_pfx;
      neg_d   = in_neg;
      width_d = in_width;
      pad_d   = in_pad;
      val_d   = in_neg ? (VALUE_BITS'(0) - in_value) : in_value;
      rem_d   = '0;
      bit_d   = BIT_W'(VALUE_BITS - 1);
      nd_d    = '0;
    end

    if (state_q == ST_DIV) begin
      val_d = quot_next;
      if (digit_done) begin
        // remainder is the next digit; quotient feeds the next pass
        rem_d = '0;
        bit_d = BIT_W'(VALUE_BITS - 1);
        nd_d  = nd_q + ND_W'(1);
        dig_d[0] = rem_next;
        for (int i = 1; i < VALUE_BITS; i++) begin
          dig_d[i] = dig_q[i-1];
        end
      end else begin
        rem_d = rem_next;
        bit_d = bit_q - BIT_W'(1);
      end
    end

    if (state_q == ST_PLAN) begin
      pad_cnt_d = pads;
    end

    if (load && (state_q == ST_PAD_LEAD || state_q == ST_PAD_FILL)) begin
      pad_cnt_d = pad_cnt_q - CNT_W'(1);
    end

    if (load && state_q == ST_DIGIT) begin
      nd_d = nd_q - ND_W'(1);
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        dig_d[i] = dig_q[i+1];
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;
    if (load) begin
      out_valid_d = emit;
      if (emit) begin
        out_char_d = emit_char;
        out_last_d = emit_last;
        out_bad_d  = emit_bad;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      nd_q        <= '0;
      bit_q       <= '0;
      pad_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      nd_q        <= nd_d;
      bit_q       <= bit_d;
      pad_cnt_q   <= pad_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q    <= radix_d;
    upper_q    <= upper_d;
    pfx_q      <= pfx_d;
    neg_q      <= neg_d;
    width_q    <= width_d;
    pad_q      <= pad_d;
    val_q      <= val_d;
    rem_q      <= rem_d;
    dig_q      <= dig_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_bad_q  <= out_bad_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_bad_q;

endmodule

// File: sv/ritoa_checker.sv
// ----------------------------------------------------------------------------
// ritoa_checker
// port-level checks of the radix integer to ascii converter
// ----------------------------------------------------------------------------
`include "radix_integer_to_ascii_top_assert.svh"

module ritoa_checker
  import ritoa_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [IN_W-1:0]   s_axis_tdata,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [CHAR_W-1:0] m_axis_tdata,
  input logic              m_axis_tlast,
  input logic              m_axis_tuser
);

  // an error beat closes its conversion
  `RITOA_ASSERT_SAME(a_bad_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "bad radix beat without last")

  // an error beat carries a null character
  `RITOA_ASSERT_SAME(a_bad_char_nul, m_axis_tvalid && m_axis_tuser, m_axis_tdata == ASCII_NUL, "bad radix beat with non-null char")

  // a taken request keeps the block busy for at least the next cycle
  `RITOA_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready straight after a request")

  // a stalled beat holds
  `RITOA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled beat changed")

endmodule

bind radix_integer_to_ascii_top ritoa_checker u_ritoa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// File: test/radix_integer_to_ascii_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_checker
// watches both streams, predicts the text of each request and checks it
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_checker
  import ritoa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [IN_W-1:0]   s_tdata_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [CHAR_W-1:0] m_tdata_i,
  input  logic              m_tlast_i,
  input  logic              m_tuser_i,
  output int unsigned       fail_count_o,
  output int unsigned       chars_pending_o,
  output int unsigned       chars_checked_o
);

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              bad;
  } text_char_t;

  text_char_t expected_text[$];

  int unsigned fail_count    = 0;
  int unsigned chars_checked = 0;

  assign fail_count_o    = fail_count;
  assign chars_pending_o = expected_text.size();
  assign chars_checked_o = chars_checked;

  // expected characters of one request, appended to expected_text
  function automatic void predict_text(input logic [IN_W-1:0] req);
    logic [NUMBER_W-1:0] value;
    logic [RADIX_W-1:0]  radix;
    logic                upper;
    logic                neg;
    logic                prefix;
    logic [CHAR_W-1:0]   fill;
    logic [CHAR_W-1:0]   d;
    logic [CHAR_W-1:0]   digits[$];
    logic [CHAR_W-1:0]   text[$];
    int unsigned         width;
    int unsigned         len;
    int unsigned         pads;
    text_char_t          beat;

    value  = req[31:0];
    radix  = req[37:32];
    upper  = req[38];
    neg    = req[39] && value[NUMBER_W-1];
    width  = 32'(req[45:40]);
    fill   = req[53:46];
    prefix = req[54];
    pads   = 0;

    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      beat.code = ASCII_NUL;
      beat.last = 1'b1;
      beat.bad  = 1'b1;
      expected_text.push_back(beat);
      return;
    end
    if (width > MAX_CHARS_DEF) width = MAX_CHARS_DEF;
    // the most negative value wraps to its own magnitude
    if (neg) value = -value;

    do begin
      d = CHAR_W'(value % radix);
      if (d < 10) digits.push_front(ASCII_ZERO + d);
      else digits.push_front((upper ? ASCII_UPPER : ASCII_LOWER) + d - 8'd10);
      value = value / radix;
    end while (value != 0);

    if (fill == ASCII_SPACE) begin
      // leading spaces go ahead of sign and prefix
      len = digits.size() + (prefix ? 2 : 0) + (neg ? 1 : 0);
      if (width > len) pads = width - len;
      repeat (pads) text.push_back(fill);
      if (neg) text.push_back(ASCII_MINUS);
      if (prefix) begin
        text.push_back(ASCII_ZERO);
        text.push_back(ASCII_X);
      end
    end else begin
      // sign and prefix first, they eat into the width
      if (neg) begin
        text.push_back(ASCII_MINUS);
        if (width != 0) width--;
      end
      if (prefix) begin
        text.push_back(ASCII_ZERO);
        text.push_back(ASCII_X);
        width = (width > 2) ? width - 2 : 0;
      end
      if (width > digits.size()) pads = width - digits.size();
      repeat (pads) text.push_back(fill);
    end
    foreach (digits[i]) text.push_back(digits[i]);

    foreach (text[i]) begin
      beat.code = text[i];
      beat.last = (i == text.size() - 1);
      beat.bad  = 1'b0;
      expected_text.push_back(beat);
    end
  endfunction

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) predict_text(s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character %h last %b bad_radix %b", m_tdata_i, m_tlast_i,
                 m_tuser_i);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          chars_checked++;
          if (m_tdata_i !== want.code) begin
            $error("char_code expected %h got %h", want.code, m_tdata_i);
            fail_count++;
          end
          if (m_tlast_i !== want.last) begin
            $error("last expected %b got %b", want.last, m_tlast_i);
            fail_count++;
          end
          if (m_tuser_i !== want.bad) begin
            $error("bad_radix expected %b got %b", want.bad, m_tuser_i);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: test/radix_integer_to_ascii_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_top_tb
// directed and random conversion requests under varying back-pressure
// ----------------------------------------------------------------------------
// A directed set covers bad radices, the widest and narrowest bases, the most
// negative value, both pad placements, saturating and too-small widths and a
// NUL fill. Random requests follow in three idling stages; in the last one
// the character side is held off for a long stretch so the block stalls its
// request side. A separate checker predicts and compares every character.
module radix_integer_to_ascii_top_tb;
  import ritoa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned HOLD_CYCLES  = 1500;
  // quiet stretch after the drain, to catch any stray tail
  localparam int unsigned TAIL_CYCLES  = 1200;
  localparam int unsigned RANDOM_ITEMS = 147;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [CHAR_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;
  logic              m_axis_tuser;

  int unsigned tx_idle_pct       = 35;
  int unsigned rx_idle_pct       = 65;
  int unsigned stage             = 0;
  int unsigned requests_accepted = 0;
  int unsigned cycle_count       = 0;
  logic        hold_rx           = 1'b0;

  int unsigned fail_count;
  int unsigned chars_pending;
  int unsigned chars_checked;

  always #6 clk_i = ~clk_i;

  radix_integer_to_ascii_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  radix_integer_to_ascii_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tlast_i       (m_axis_tlast),
    .m_tuser_i       (m_axis_tuser),
    .fail_count_o    (fail_count),
    .chars_pending_o (chars_pending),
    .chars_checked_o (chars_checked)
  );

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // character side: random stalls, plus the long hold-off when asked
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
  end

  // long hold-off in the stage without idling: the block keeps its text
  // waiting and drops s_axis_tready while the sender keeps offering
  initial begin
    wait (stage == 2);
    repeat (200) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // packs the request fields, lowest field in the lowest bits
  function automatic logic [IN_W-1:0] make_request(
    input logic [NUMBER_W-1:0] number,
    input logic [RADIX_W-1:0]  radix,
    input logic                upper,
    input logic                sgn,
    input logic [WIDTH_W-1:0]  width,
    input logic [CHAR_W-1:0]   fill,
    input logic                prefix
  );
    return {1'b0, prefix, fill, width, sgn, upper, radix, number};
  endfunction

  // offers one request after a random gap and waits for its handshake
  task automatic send_request(input logic [IN_W-1:0] req);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_accepted++;
  endtask

  initial begin
    logic [NUMBER_W-1:0] number;
    logic [RADIX_W-1:0]  radix;
    logic [WIDTH_W-1:0]  width;
    logic [CHAR_W-1:0]   fill;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed requests: sender idles 35 in 100, receiver 65 in 100
    send_request(make_request(32'd0, 6'd10, 1'b0, 1'b0, 6'd0, ASCII_SPACE, 1'b0));
    send_request(make_request(32'hffff_ffff, 6'd2, 1'b0, 1'b0, 6'd0, ASCII_SPACE, 1'b0));
    send_request(make_request(32'h8000_0000, 6'd2, 1'b1, 1'b1, 6'd0, ASCII_ZERO, 1'b1));
    send_request(make_request(32'h8000_0000, 6'd10, 1'b0, 1'b1, 6'd0, ASCII_SPACE, 1'b0));
    send_request(make_request(32'hffff_ffff, 6'd16, 1'b0, 1'b1, 6'd0, ASCII_SPACE, 1'b0));
    // radices outside 2 to 36, the last with every other field set
    send_request(make_request(32'd1234, 6'd0, 1'b0, 1'b0, 6'd5, ASCII_SPACE, 1'b0));
    send_request(make_request(32'd1234, 6'd1, 1'b1, 1'b0, 6'd5, ASCII_ZERO, 1'b1));
    send_request(make_request(32'd1234, 6'd37, 1'b0, 1'b1, 6'd5, ASCII_SPACE, 1'b0));
    send_request(make_request(32'hffff_ffff, 6'd63, 1'b1, 1'b1, 6'd63, 8'hff, 1'b1));
    // letter digits in both cases
    send_request(make_request(32'h7fff_ffff, 6'd36, 1'b0, 1'b0, 6'd0, ASCII_SPACE, 1'b0));
    send_request(make_request(32'hffff_ffff, 6'd36, 1'b1, 1'b0, 6'd0, ASCII_SPACE, 1'b0));
    send_request(make_request(32'hdead_beef, 6'd16, 1'b1, 1'b0, 6'd0, ASCII_SPACE, 1'b1));
    // space pad before sign and prefix, zero pad after them
    send_request(make_request(32'hffff_ff85, 6'd16, 1'b0, 1'b1, 6'd20, ASCII_SPACE, 1'b1));
    send_request(make_request(32'hffff_ff85, 6'd16, 1'b0, 1'b1, 6'd12, ASCII_ZERO, 1'b1));
    // oversized width saturates, largest legal width
    send_request(make_request(32'd42, 6'd10, 1'b0, 1'b0, 6'd63, 8'h2a, 1'b0));
    send_request(make_request(32'd42, 6'd10, 1'b0, 1'b1, 6'd48, ASCII_SPACE, 1'b1));
    // nul fill, width below the text, width eaten by sign and prefix
    send_request(make_request(32'd7, 6'd8, 1'b0, 1'b0, 6'd10, ASCII_NUL, 1'b0));
    send_request(make_request(32'd123456, 6'd10, 1'b0, 1'b0, 6'd3, ASCII_ZERO, 1'b0));
    send_request(make_request(32'hffff_fff6, 6'd10, 1'b0, 1'b1, 6'd2, 8'h2e, 1'b1));
    send_request(make_request(32'hffff_fff6, 6'd10, 1'b0, 1'b1, 6'd1, 8'h2e, 1'b0));
    send_request(make_request(32'h0000_00a5, 6'd2, 1'b0, 1'b0, 6'd40, 8'hff, 1'b0));
    send_request(make_request(32'd0, 6'd2, 1'b0, 1'b1, 6'd4, ASCII_ZERO, 1'b1));
    send_request(make_request(32'h7fff_ffff, 6'd10, 1'b1, 1'b1, 6'd0, ASCII_ZERO, 1'b0));

    // random requests in three idling stages
    for (int s = 0; s < 3; s++) begin
      stage = s;
      case (s)
        0: begin
          tx_idle_pct = 35;
          rx_idle_pct <= 65;
        end
        1: begin
          tx_idle_pct = 65;
          rx_idle_pct <= 35;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      repeat (RANDOM_ITEMS / 3) begin
        case ($urandom_range(4))
          0:       number = $urandom_range(20);
          1:       number = -$urandom_range(1000, 1);
          2: begin
            case ($urandom_range(3))
              0:       number = 32'h0;
              1:       number = 32'hffff_ffff;
              2:       number = 32'h8000_0000;
              default: number = 32'h7fff_ffff;
            endcase
          end
          default: number = $urandom;
        endcase
        // mostly legal bases, now and then any six-bit value
        if ($urandom_range(9) == 0) radix = RADIX_W'($urandom_range(63));
        else radix = RADIX_W'($urandom_range(36, 2));
        if ($urandom_range(3) == 0) width = WIDTH_W'($urandom_range(63));
        else width = WIDTH_W'($urandom_range(16));
        case ($urandom_range(3))
          0, 1:    fill = ASCII_SPACE;
          2:       fill = ASCII_ZERO;
          default: fill = CHAR_W'($urandom_range(255));
        endcase
        send_request(make_request(number, radix, 1'($urandom_range(1)),
                                  1'($urandom_range(1)), width, fill,
                                  1'($urandom_range(1))));
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give the block room to show any stray character
    @(negedge clk_i);
    while (chars_pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);

    $display("converted %0d requests into %0d checked characters", requests_accepted,
             chars_checked);
    $display("idling stages 35/65, 65/35 and none, with a %0d cycle output hold-off",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/ritoa_pkg.sv
sv/radix_integer_to_ascii_top.sv
sv/ritoa_checker.sv
test/radix_integer_to_ascii_checker.sv
test/radix_integer_to_ascii_top_tb.sv
